// ----- rtl/gda_pkg.sv -----
`timescale 1ns / 1ps

package gda_pkg;

  localparam int OpW     = 2;
  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int OffsetW = 23;
  localparam int DiffW   = 22;
  localparam int StatusW = 2;

  localparam int MaxYearDefault = 9999;
  localparam int DaysPerYear    = 365;
  localparam int LeapYearDays   = 366;
  localparam int MonthsPerYear  = 12;
  localparam int Century        = 100;
  localparam int QuadCentury    = 400;
  localparam int DaysPer400     = 146097;
  localparam int DiffMax        = (1 << DiffW) - 1;

  typedef enum logic [OpW-1:0] {
    OP_ADD  = 2'd0,
    OP_DIFF = 2'd1,
    OP_CMP  = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_DATE = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_e;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_CHK   = 11'b000_0000_0010,
    ST_DBY_M = 11'b000_0000_0100,
    ST_DBY_H = 11'b000_0000_1000,
    ST_DBY_S = 11'b000_0001_0000,
    ST_POST  = 11'b000_0010_0000,
    ST_EST_M = 11'b000_0100_0000,
    ST_EST_H = 11'b000_1000_0000,
    ST_FIX   = 11'b001_0000_0000,
    ST_MWALK = 11'b010_0000_0000,
    ST_FIN   = 11'b100_0000_0000
  } state_e;

  // days from the first day of year one to january 1 of year y
  function automatic int days_before_year(input int y);
    int p;
    p = y - 1;
    return p * DaysPerYear + p / 4 - p / Century + p / QuadCentury;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] m,
                                                   input logic leap);
    logic [8:0] cum;
    case (m)
      4'd1:  cum = 9'd0;
      4'd2:  cum = 9'd31;
      4'd3:  cum = 9'd59;
      4'd4:  cum = 9'd90;
      4'd5:  cum = 9'd120;
      4'd6:  cum = 9'd151;
      4'd7:  cum = 9'd181;
      4'd8:  cum = 9'd212;
      4'd9:  cum = 9'd243;
      4'd10: cum = 9'd273;
      4'd11: cum = 9'd304;
      4'd12: cum = 9'd334;
      default: cum = 9'd0;
    endcase
    if (leap && m > 4'd2) begin
      cum = cum + 9'd1;
    end
    return cum;
  endfunction

endpackage

// ----- rtl/gregorian_date_arithmetic_top.sv -----
// channel  role         handshake                  payload
// in       request in   in_valid_i / in_stall_o    op_i, first_*_i, second_*_i, day_offset_i
// out      result out   out_valid_o / out_stall_i  result_*_o, days_between_o, first_is_less_o,
//                                                  dates_equal_o, status_o
// one request at a time; each year start is built on the shared multiplier (two years)
// diff and compare convert both dates; invalid dates, unknown ops, add range errors end early
// add estimates the year, corrects it one year at a time, then walks months one per cycle
// reset is asynchronous active low and clears state, phase, sel, fix and output valid only
// in_stall_o is high from acceptance until the result moves into the output register
// the output register holds while out_stall_i is high and the next request is taken meanwhile
`timescale 1ns / 1ps

module gregorian_date_arithmetic_top #(
  parameter int MAX_YEAR = gda_pkg::MaxYearDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [gda_pkg::OpW-1:0]            op_i,
  input  logic [gda_pkg::YearW-1:0]          first_year_i,
  input  logic [gda_pkg::MonthW-1:0]         first_month_i,
  input  logic [gda_pkg::DayW-1:0]           first_day_i,
  input  logic [gda_pkg::YearW-1:0]          second_year_i,
  input  logic [gda_pkg::MonthW-1:0]         second_month_i,
  input  logic [gda_pkg::DayW-1:0]           second_day_i,
  input  logic signed [gda_pkg::OffsetW-1:0] day_offset_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [gda_pkg::YearW-1:0]          result_year_o,
  output logic [gda_pkg::MonthW-1:0]         result_month_o,
  output logic [gda_pkg::DayW-1:0]           result_day_o,
  output logic [gda_pkg::DiffW-1:0]          days_between_o,
  output logic                               first_is_less_o,
  output logic                               dates_equal_o,
  output logic [gda_pkg::StatusW-1:0]        status_o
);
  import gda_pkg::*;

  localparam int LastDay   = days_before_year(MAX_YEAR + 1) - 1;
  localparam int YW        = $clog2(MAX_YEAR + 3);
  localparam int NW        = $clog2(LastDay + (1 << (OffsetW - 1)) + 2 * LeapYearDays) + 1;
  localparam int DivShift  = YW + 7;
  localparam int DivMul    = ((1 << DivShift) + Century - 1) / Century;
  localparam int EstShift  = 30;
  localparam longint EstMulL = ((longint'(1) << EstShift) * QuadCentury) / DaysPer400;
  localparam int EstMul    = int'(EstMulL);
  localparam int EstMulW   = $clog2(EstMul + 1);
  localparam int DivMulW   = $clog2(DivMul + 1);
  localparam int BW        = (EstMulW > DivMulW) ? EstMulW : DivMulW;
  localparam int AW        = NW;
  localparam int PW        = AW + BW;

  state_e state_q, state_d;

  logic [OpW-1:0]            op_q;
  logic [YearW-1:0]          first_year_q, second_year_q;
  logic [MonthW-1:0]         first_month_q, second_month_q;
  logic [DayW-1:0]           first_day_q, second_day_q;
  logic signed [OffsetW-1:0] day_offset_q;

  logic [YW-1:0]    yr_q, yr_d, p_q, p_d, q_q, q_d;
  logic             phase_q, phase_d, sel_q, sel_d, fix_q, fix_d, leap_q, leap_d;
  logic signed [NW-1:0] jan0_q, jan0_d, jan1_q, jan1_d, n_q, n_d, a_q, a_d;
  logic [8:0]       rem_q, rem_d;
  logic [MonthW-1:0] mo_q, mo_d;

  status_e          res_status_q, res_status_d;
  logic             res_date_q, res_date_d, res_less_q, res_less_d, res_eq_q, res_eq_d;
  logic [DiffW-1:0] res_diff_q, res_diff_d;

  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] mul_q;

  logic                  out_valid_q, out_valid_d, out_load;
  logic [YearW-1:0]      out_year_q;
  logic [MonthW-1:0]     out_month_q;
  logic [DayW-1:0]       out_day_q;
  logic [DiffW-1:0]      out_diff_q;
  logic                  out_less_q, out_eq_q;
  status_e               out_status_q;

  logic                  in_accept;
  logic [MonthW-1:0]     cur_m;
  logic [DayW-1:0]       cur_d, mlen_w, mlen_walk;
  logic signed [NW-1:0]  yr_len, num_w, n_w, dby_sum, dif_w, absd_w;
  logic                  leap_w, day_ok, range_bad;
  logic                  yok1, yok2, mok1, mok2;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign cur_m     = sel_q ? second_month_q : first_month_q;
  assign cur_d     = sel_q ? second_day_q : first_day_q;
  assign yr_len    = jan1_q - jan0_q;
  assign leap_w    = (yr_len == NW'(LeapYearDays));
  assign mlen_w    = month_len(cur_m, leap_w);
  assign day_ok    = (cur_d != '0) && (cur_d <= mlen_w);
  assign num_w     = jan0_q + $signed(NW'(days_before_month(cur_m, leap_w)))
                     + $signed(NW'(cur_d)) - $signed(NW'(1));
  assign n_w       = num_w + NW'(day_offset_q);
  assign range_bad = (n_w < $signed(NW'(0))) || (n_w > $signed(NW'(LastDay)));
  assign dby_sum   = NW'(mul_q) + NW'(p_q >> 2) - NW'(q_q) + NW'(q_q >> 2);
  assign dif_w     = a_q - num_w;
  assign absd_w    = (dif_w < $signed(NW'(0))) ? -dif_w : dif_w;
  assign mlen_walk = month_len(mo_q, leap_q);

  assign yok1 = (first_year_q != '0) && (32'(first_year_q) <= 32'(MAX_YEAR));
  assign yok2 = (second_year_q != '0) && (32'(second_year_q) <= 32'(MAX_YEAR));
  assign mok1 = (first_month_q != '0) && (first_month_q <= MonthW'(MonthsPerYear));
  assign mok2 = (second_month_q != '0) && (second_month_q <= MonthW'(MonthsPerYear));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_DBY_M: begin
        mul_a = AW'(p_q);
        mul_b = BW'(DivMul);
      end
      ST_DBY_H: begin
        mul_a = AW'(p_q);
        mul_b = BW'(DaysPerYear);
      end
      ST_EST_M: begin
        mul_a = AW'($unsigned(n_q));
        mul_b = BW'(EstMul);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    yr_d         = yr_q;
    p_d          = p_q;
    q_d          = q_q;
    phase_d      = phase_q;
    sel_d        = sel_q;
    fix_d        = fix_q;
    leap_d       = leap_q;
    jan0_d       = jan0_q;
    jan1_d       = jan1_q;
    n_d          = n_q;
    a_d          = a_q;
    rem_d        = rem_q;
    mo_d         = mo_q;
    res_status_d = res_status_q;
    res_date_d   = res_date_q;
    res_less_d   = res_less_q;
    res_eq_d     = res_eq_q;
    res_diff_d   = res_diff_q;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_status_d = STATUS_OK;
          res_date_d   = 1'b0;
          res_less_d   = 1'b0;
          res_eq_d     = 1'b0;
          res_diff_d   = '0;
          state_d      = ST_CHK;
        end
      end
      ST_CHK: begin
        yr_d    = YW'(first_year_q);
        p_d     = YW'(first_year_q) - YW'(1);
        phase_d = 1'b0;
        sel_d   = 1'b0;
        fix_d   = 1'b0;
        if (op_q == OP_ADD) begin
          if (yok1 && mok1) begin
            state_d = ST_DBY_M;
          end else begin
            res_status_d = STATUS_BAD_DATE;
            state_d      = ST_FIN;
          end
        end else if (op_q == OP_DIFF || op_q == OP_CMP) begin
          if (yok1 && mok1 && yok2 && mok2) begin
            state_d = ST_DBY_M;
          end else begin
            res_status_d = STATUS_BAD_DATE;
            state_d      = ST_FIN;
          end
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DBY_M: begin
        state_d = ST_DBY_H;
      end
      ST_DBY_H: begin
        q_d     = YW'(mul_q >> DivShift);
        state_d = ST_DBY_S;
      end
      ST_DBY_S: begin
        if (!phase_q) begin
          jan0_d  = dby_sum;
          phase_d = 1'b1;
          p_d     = p_q + YW'(1);
          state_d = ST_DBY_M;
        end else begin
          jan1_d  = dby_sum;
          phase_d = 1'b0;
          state_d = fix_q ? ST_FIX : ST_POST;
        end
      end
      ST_POST: begin
        if (!day_ok) begin
          res_status_d = STATUS_BAD_DATE;
          state_d      = ST_FIN;
        end else if (op_q == OP_ADD) begin
          if (range_bad) begin
            res_status_d = STATUS_RANGE;
            state_d      = ST_FIN;
          end else begin
            n_d     = n_w;
            state_d = ST_EST_M;
          end
        end else if (!sel_q) begin
          a_d     = num_w;
          sel_d   = 1'b1;
          yr_d    = YW'(second_year_q);
          p_d     = YW'(second_year_q) - YW'(1);
          state_d = ST_DBY_M;
        end else begin
          if (op_q == OP_DIFF) begin
            res_diff_d = (absd_w > $signed(NW'(DiffMax))) ? DiffW'(DiffMax) : DiffW'(absd_w);
          end else begin
            res_less_d = (a_q < num_w);
            res_eq_d   = (a_q == num_w);
          end
          state_d = ST_FIN;
        end
      end
      ST_EST_M: begin
        state_d = ST_EST_H;
      end
      ST_EST_H: begin
        p_d     = YW'(mul_q >> EstShift);
        yr_d    = YW'(mul_q >> EstShift) + YW'(1);
        phase_d = 1'b0;
        fix_d   = 1'b1;
        state_d = ST_DBY_M;
      end
      ST_FIX: begin
        if (jan0_q > n_q) begin
          yr_d    = yr_q - YW'(1);
          p_d     = yr_q - YW'(2);
          state_d = ST_DBY_M;
        end else if (jan1_q <= n_q) begin
          yr_d    = yr_q + YW'(1);
          p_d     = yr_q;
          state_d = ST_DBY_M;
        end else begin
          rem_d   = 9'(n_q - jan0_q);
          leap_d  = leap_w;
          mo_d    = MonthW'(1);
          state_d = ST_MWALK;
        end
      end
      ST_MWALK: begin
        if (mo_q < MonthW'(MonthsPerYear) && rem_q >= 9'(mlen_walk)) begin
          rem_d = rem_q - 9'(mlen_walk);
          mo_d  = mo_q + MonthW'(1);
        end else begin
          res_date_d = 1'b1;
          state_d    = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      sel_q       <= 1'b0;
      fix_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      sel_q       <= sel_d;
      fix_q       <= fix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q           <= op_i;
      first_year_q   <= first_year_i;
      first_month_q  <= first_month_i;
      first_day_q    <= first_day_i;
      second_year_q  <= second_year_i;
      second_month_q <= second_month_i;
      second_day_q   <= second_day_i;
      day_offset_q   <= day_offset_i;
    end
    mul_q        <= mul_a * mul_b;
    yr_q         <= yr_d;
    p_q          <= p_d;
    q_q          <= q_d;
    leap_q       <= leap_d;
    jan0_q       <= jan0_d;
    jan1_q       <= jan1_d;
    n_q          <= n_d;
    a_q          <= a_d;
    rem_q        <= rem_d;
    mo_q         <= mo_d;
    res_status_q <= res_status_d;
    res_date_q   <= res_date_d;
    res_less_q   <= res_less_d;
    res_eq_q     <= res_eq_d;
    res_diff_q   <= res_diff_d;
    if (out_load) begin
      out_year_q   <= res_date_q ? YearW'(yr_q) : '0;
      out_month_q  <= res_date_q ? mo_q : '0;
      out_day_q    <= res_date_q ? DayW'(rem_q + 9'd1) : '0;
      out_diff_q   <= res_diff_q;
      out_less_q   <= res_less_q;
      out_eq_q     <= res_eq_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_year_o   = out_year_q;
  assign result_month_o  = out_month_q;
  assign result_day_o    = out_day_q;
  assign days_between_o  = out_diff_q;
  assign first_is_less_o = out_less_q;
  assign dates_equal_o   = out_eq_q;
  assign status_o        = out_status_q;

  a_year_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIX |-> (yr_len == NW'(DaysPerYear) || yr_len == NW'(LeapYearDays)))
    else $error("year length out of range at estimate correction");

  a_month_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MWALK |-> (mo_q != '0 && mo_q <= MonthW'(MonthsPerYear)))
    else $error("month walk left the year");

  a_cmp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dates_equal_o |-> !first_is_less_o)
    else $error("equal dates reported as less");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |->
      (result_year_o == '0 && result_month_o == '0 && result_day_o == '0 &&
       days_between_o == '0 && !first_is_less_o && !dates_equal_o))
    else $error("error result carries data");

  a_date_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_month_o != '0 |->
      (result_day_o != '0 && result_month_o <= MonthW'(MonthsPerYear) &&
       result_year_o != '0))
    else $error("malformed result date");

endmodule
